### src/round_robin_thread_scheduler_core_defines.svh
// Assertion macros for the round-robin thread scheduler core.
// Included by the top level; no other dependencies.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### src/rrts_pkg.sv
// Shared codes for the round-robin thread scheduler: operations, slot states, status.
// No dependencies.
`default_nettype none
package rrts_pkg;
  localparam logic [2:0] FN_CREATE = 3'd0;
  localparam logic [2:0] FN_YIELD  = 3'd1;
  localparam logic [2:0] FN_EXIT   = 3'd2;
  localparam logic [2:0] FN_JOIN   = 3'd3;
  localparam logic [2:0] FN_WAIT   = 3'd4;
  localparam logic [2:0] FN_NOTIFY = 3'd5;

  localparam logic [2:0] ST_EMPTY   = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_ZOMBIE  = 3'd4;
  localparam logic [2:0] ST_DEAD    = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_NOTHR = 2'd2;
  localparam logic [1:0] STAT_IDLE  = 2'd3;

  typedef logic [2:0] slot_state_t;
endpackage
`default_nettype wire

### src/rrts_ifs.sv
// Request and response channel interfaces of the scheduler.
// Standalone; payload widths are fixed.
`default_nettype none
interface rrts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  target_slot;
  logic [31:0] ret_value;
  modport source (output valid, func, target_slot, ret_value, input ready);
  modport sink   (input valid, func, target_slot, ret_value, output ready);
endinterface

interface rrts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  new_slot;
  logic [2:0]  running_slot;
  logic        running_valid;
  logic        switched;
  logic        join_done;
  logic [31:0] join_value;
  modport source (output valid, status, new_slot, running_slot, running_valid, switched,
                  join_done, join_value, input ready);
  modport sink   (input valid, status, new_slot, running_slot, running_valid, switched,
                  join_done, join_value, output ready);
endinterface
`default_nettype wire

### src/round_robin_thread_scheduler_core.sv
// Top level of the round-robin thread scheduler: sequencer, slot states, two RAMs.
// Depends on rrts_pkg, rrts_ifs, rrts_ram and the defines header.
//
//   channel | modport | payload
//   req     | sink    | func, target_slot, ret_value
//   rsp     | source  | status, new_slot, running_slot, running_valid, switched,
//           |         | join_done, join_value
//
// One transaction is handled at a time: decode, the operation, a free-slot scan of up
// to SLOT_COUNT slots for create (one slot per cycle), an election scan of up to
// SLOT_COUNT slots and a join-target lookup (S_JT, then S_EV for a zombie target).
// The scans step one slot a cycle; exit value and links live in RAMs with a registered read.
// Synchronous reset clears all slots to empty, current slot 0, idle; no clearing pass.
// A result that is not taken holds the output register; req.ready stays low until it drains.
`default_nettype none
`include "round_robin_thread_scheduler_core_defines.svh"
module round_robin_thread_scheduler_core #(
  parameter int SLOT_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst,
  rrts_req_if.sink   req,
  rrts_rsp_if.source rsp
);
  import rrts_pkg::*;

  localparam int IDXW = $clog2(SLOT_COUNT);
  localparam int LW   = IDXW + 1;          // link: valid bit over slot index
  localparam int AW   = 32 + LW;           // exit value over waiter link
  localparam logic [IDXW-1:0] LAST = IDXW'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_OP     = 3'd2;
  localparam logic [2:0] S_FIND   = 3'd3;
  localparam logic [2:0] S_ELECT  = 3'd4;
  localparam logic [2:0] S_JT     = 3'd5;
  localparam logic [2:0] S_EV     = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]      fsm;
  slot_state_t     st [SLOT_COUNT];
  logic [IDXW-1:0] cur;
  logic            idle;
  logic [2:0]      func_q;
  logic [2:0]      tgt_q;
  logic [31:0]     rv_q;
  logic            was_idle;
  logic [IDXW-1:0] was_slot;
  logic [1:0]      status_q;
  logic [2:0]      newslot_q;
  logic            jdone_q;
  logic [31:0]     jvalue_q;
  logic [IDXW-1:0] sp;
  logic [IDXW-1:0] cnt;
  logic [IDXW-1:0] jt_q;

  // RAM A holds {exit value, waiter link}; RAM B holds the join-target link
  logic            a_we;
  logic [IDXW-1:0] a_waddr;
  logic [AW-1:0]   a_wdata;
  logic [IDXW-1:0] a_raddr;
  logic [AW-1:0]   a_rdata;
  logic            b_we;
  logic [IDXW-1:0] b_waddr;
  logic [LW-1:0]   b_wdata;
  logic [IDXW-1:0] b_raddr;
  logic [LW-1:0]   b_rdata;

  rrts_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_ev_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  rrts_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_jt_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  logic [31:0]     a_ev;
  logic            w_val;
  logic [IDXW-1:0] w_idx;
  logic            jt_val;
  logic [IDXW-1:0] jt_idx;
  logic            tgt_ok;
  logic [IDXW-1:0] tgt_idx;
  logic            join_bad;
  logic [IDXW-1:0] sp_first;

  assign a_ev     = a_rdata[AW-1:LW];
  assign w_val    = a_rdata[LW-1];
  assign w_idx    = a_rdata[IDXW-1:0];
  assign jt_val   = b_rdata[LW-1];
  assign jt_idx   = b_rdata[IDXW-1:0];
  assign tgt_ok   = ({29'd0, tgt_q} < 32'(SLOT_COUNT));
  assign tgt_idx  = IDXW'(tgt_q);
  assign join_bad = !tgt_ok || (tgt_idx == cur) || (st[tgt_idx] == ST_EMPTY) ||
                    (st[tgt_idx] == ST_DEAD);
  assign sp_first = (cur == LAST) ? '0 : cur + 1'b1;

  assign req.ready = (fsm == S_IDLE);

  // RAM addressing: exit and join read their entry in S_DECODE, election reads the
  // join link of the elected slot, and a zombie join target reads its exit value
  always_comb begin
    a_raddr = cur;
    if (fsm == S_DECODE && func_q == FN_JOIN) begin
      a_raddr = tgt_idx;
    end else if (fsm == S_JT) begin
      a_raddr = jt_idx;
    end
    b_raddr = sp;

    a_we    = 1'b0;
    a_waddr = cur;
    a_wdata = {rv_q, a_rdata[LW-1:0]};
    b_we    = 1'b0;
    b_waddr = cur;
    b_wdata = '0;
    case (fsm)
      S_FIND: begin
        if (st[sp] == ST_EMPTY) begin
          // fresh slot: zero exit value, no waiter, no join target
          a_we    = 1'b1;
          a_waddr = sp;
          a_wdata = '0;
          b_we    = 1'b1;
          b_waddr = sp;
        end
      end
      S_OP: begin
        if (!idle && func_q == FN_EXIT) begin
          a_we = 1'b1;
        end else if (!idle && func_q == FN_JOIN && !join_bad) begin
          // record the caller as waiter, keep the exit value
          a_we    = 1'b1;
          a_waddr = tgt_idx;
          a_wdata = {a_ev, 1'b1, cur};
          if (st[tgt_idx] != ST_ZOMBIE) begin
            b_we    = 1'b1;
            b_wdata = {1'b1, tgt_idx};
          end
        end
      end
      S_JT: begin
        // drop the join target of the thread just elected
        b_we = jt_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      cur       <= '0;
      idle      <= 1'b1;
      rsp.valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st[i] <= ST_EMPTY;
      end
    end else begin
      // S_DONE reloads the output register itself
      if (rsp.valid && rsp.ready && fsm != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (req.valid) begin
            func_q    <= req.func;
            tgt_q     <= req.target_slot;
            rv_q      <= req.ret_value;
            was_idle  <= idle;
            was_slot  <= cur;
            status_q  <= STAT_OK;
            newslot_q <= '0;
            jdone_q   <= 1'b0;
            jvalue_q  <= '0;
            fsm       <= S_DECODE;
          end
        end
        S_DECODE: begin
          fsm <= S_OP;
        end
        S_OP: begin
          case (func_q)
            FN_CREATE: begin
              sp  <= '0;
              fsm <= S_FIND;
            end
            FN_NOTIFY: begin
              if (!tgt_ok || st[tgt_idx] == ST_EMPTY) begin
                status_q <= STAT_NOTHR;
                fsm      <= S_DONE;
              end else begin
                if (st[tgt_idx] == ST_RUNNING || st[tgt_idx] == ST_WAITING) begin
                  st[tgt_idx] <= ST_READY;
                end
                if (!idle) begin
                  fsm <= S_DONE;
                end else begin
                  sp  <= sp_first;
                  cnt <= '0;
                  fsm <= S_ELECT;
                end
              end
            end
            FN_YIELD, FN_EXIT, FN_JOIN, FN_WAIT: begin
              if (idle) begin
                status_q <= STAT_IDLE;
                fsm      <= S_DONE;
              end else if (func_q == FN_JOIN && join_bad) begin
                status_q <= STAT_NOTHR;
                fsm      <= S_DONE;
              end else if (func_q == FN_JOIN && st[tgt_idx] == ST_ZOMBIE) begin
                // joined thread already finished: complete at once
                jdone_q     <= 1'b1;
                jvalue_q    <= a_ev;
                st[tgt_idx] <= ST_DEAD;
                fsm         <= S_DONE;
              end else begin
                // update the caller, then elect
                sp  <= sp_first;
                cnt <= '0;
                fsm <= S_ELECT;
                case (func_q)
                  FN_YIELD: begin
                    st[cur] <= ST_READY;
                  end
                  FN_EXIT: begin
                    st[cur] <= ST_ZOMBIE;
                    if (w_val && st[w_idx] == ST_WAITING) begin
                      st[w_idx] <= ST_READY;
                    end
                  end
                  FN_JOIN: begin
                    st[cur] <= ST_WAITING;
                  end
                  default: begin
                    if (st[cur] == ST_RUNNING) begin
                      st[cur] <= ST_WAITING;
                    end
                  end
                endcase
              end
            end
            default: begin
              fsm <= S_DONE;
            end
          endcase
        end
        S_FIND: begin
          // lowest empty slot, one slot per cycle
          if (st[sp] == ST_EMPTY) begin
            st[sp]    <= ST_READY;
            newslot_q <= 3'(sp);
            if (idle) begin
              sp  <= sp_first;
              cnt <= '0;
              fsm <= S_ELECT;
            end else begin
              fsm <= S_DONE;
            end
          end else if (sp == LAST) begin
            status_q <= STAT_FULL;
            fsm      <= S_DONE;
          end else begin
            sp <= sp + 1'b1;
          end
        end
        S_ELECT: begin
          // circular scan from current+1, ending with current itself
          if (st[sp] == ST_READY) begin
            cur    <= sp;
            st[sp] <= ST_RUNNING;
            idle   <= 1'b0;
            fsm    <= S_JT;
          end else if (cnt == LAST) begin
            idle <= 1'b1;
            fsm  <= S_DONE;
          end else begin
            sp  <= (sp == LAST) ? '0 : sp + 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        S_JT: begin
          if (jt_val && st[jt_idx] == ST_ZOMBIE) begin
            jt_q <= jt_idx;
            fsm  <= S_EV;
          end else begin
            fsm <= S_DONE;
          end
        end
        S_EV: begin
          jdone_q  <= 1'b1;
          jvalue_q <= a_ev;
          st[jt_q] <= ST_DEAD;
          fsm      <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= idle ? STAT_IDLE : status_q;
            rsp.new_slot      <= newslot_q;
            rsp.running_slot  <= idle ? 3'd0 : 3'(cur);
            rsp.running_valid <= !idle;
            rsp.switched      <= (was_idle != idle) || (!idle && was_slot != cur);
            rsp.join_done     <= jdone_q;
            rsp.join_value    <= jvalue_q;
            fsm               <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_cur_live, clk, rst, (fsm == S_IDLE) && !idle,
    (st[cur] == ST_RUNNING) || (st[cur] == ST_READY))
  `ASSERT_IMPLIES(a_idle_status, clk, rst, rsp.valid,
    (rsp.status == STAT_IDLE) == !rsp.running_valid)
  `ASSERT_NEXT(a_accept_decode, clk, rst, req.valid && req.ready, fsm == S_DECODE)
endmodule
`default_nettype wire

### src/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### tb/sv/tb_round_robin_thread_scheduler_core.sv
// Self-checking testbench for the round-robin thread scheduler core.
// Depends on rrts_pkg, rrts_ifs and round_robin_thread_scheduler_core.
`default_nettype none
module tb_round_robin_thread_scheduler_core;
  import rrts_pkg::*;

  localparam int NSLOT = 8;
  localparam logic [3:0] NO_SLOT = 4'd8;
  localparam int RANDOM_OPS = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrts_req_if req ();
  rrts_rsp_if rsp ();

  round_robin_thread_scheduler_core #(.SLOT_COUNT(NSLOT)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // One result transaction as the scheduler reports it.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_slot;
    logic [2:0]  running_slot;
    logic        running_valid;
    logic        switched;
    logic        join_done;
    logic [31:0] join_value;
  } sched_result_t;

  // Directed row: the operation and, where obvious, the result typed in.
  typedef struct {
    logic [2:0]    func;
    logic [2:0]    tgt;
    logic [31:0]   rv;
    bit            typed;
    sched_result_t res;
  } op_row_t;

  // Shadow copy of the slot table.
  slot_state_t thr_state[NSLOT];
  logic [3:0]  thr_waiter[NSLOT];
  logic [3:0]  thr_joining[NSLOT];
  logic [31:0] thr_exit_val[NSLOT];
  logic [2:0]  cur_slot;
  logic        sched_idle;
  logic        join_hit;
  logic [31:0] join_val;

  sched_result_t pending_results[$];
  // Typed results of directed rows, keyed by transaction number.
  sched_result_t typed_exp[int];
  int n_mismatch = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_pred = 0;
  int n_joins = 0;
  bit stim_done = 1'b0;
  bit quiet = 1'b0;

  task automatic clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      thr_state[i] = ST_EMPTY;
      thr_waiter[i] = NO_SLOT;
      thr_joining[i] = NO_SLOT;
      thr_exit_val[i] = '0;
    end
    cur_slot = '0;
    sched_idle = 1'b1;
  endtask

  // Circular scan from the slot after the current one; the elected thread
  // resolves its pending join, completing it when the target is a zombie.
  task automatic elect_next();
    int s;
    logic [3:0] t;
    for (int i = 1; i <= NSLOT; i++) begin
      s = (cur_slot + i) % NSLOT;
      if (thr_state[s] == ST_READY) begin
        t = thr_joining[s];
        cur_slot = s[2:0];
        thr_state[s] = ST_RUNNING;
        sched_idle = 1'b0;
        if (t < NO_SLOT) begin
          if (thr_state[t[2:0]] == ST_ZOMBIE) begin
            join_hit = 1'b1;
            join_val = thr_exit_val[t[2:0]];
            thr_state[t[2:0]] = ST_DEAD;
          end
          thr_joining[s] = NO_SLOT;
        end
        return;
      end
    end
    sched_idle = 1'b1;
  endtask

  function automatic int lowest_free();
    for (int i = 0; i < NSLOT; i++)
      if (thr_state[i] == ST_EMPTY) return i;
    return NSLOT;
  endfunction

  // Apply one operation to the shadow table and return its result.
  task automatic schedule_op(input logic [2:0] func, input logic [2:0] tgt,
                             input logic [31:0] rv, output sched_result_t r);
    logic was_idle;
    logic [2:0] was_slot;
    logic [2:0] cur;
    logic [1:0] st;
    logic [2:0] nslot;
    logic [3:0] w;
    int f;
    was_idle = sched_idle;
    was_slot = cur_slot;
    cur = cur_slot;
    st = STAT_OK;
    nslot = '0;
    join_hit = 1'b0;
    join_val = '0;
    case (func)
      FN_CREATE: begin
        f = lowest_free();
        if (f == NSLOT) begin
          st = STAT_FULL;
        end else begin
          thr_state[f] = ST_READY;
          thr_waiter[f] = NO_SLOT;
          thr_joining[f] = NO_SLOT;
          thr_exit_val[f] = '0;
          nslot = f[2:0];
          if (sched_idle) elect_next();
        end
      end
      FN_NOTIFY: begin
        if (thr_state[tgt] == ST_EMPTY) begin
          st = STAT_NOTHR;
        end else begin
          if (thr_state[tgt] == ST_RUNNING || thr_state[tgt] == ST_WAITING)
            thr_state[tgt] = ST_READY;
          if (sched_idle) elect_next();
        end
      end
      FN_YIELD, FN_EXIT, FN_JOIN, FN_WAIT: begin
        if (sched_idle) begin
          st = STAT_IDLE;
        end else if (func == FN_YIELD) begin
          thr_state[cur] = ST_READY;
          elect_next();
        end else if (func == FN_EXIT) begin
          w = thr_waiter[cur];
          thr_exit_val[cur] = rv;
          thr_state[cur] = ST_ZOMBIE;
          if (w < NO_SLOT && thr_state[w[2:0]] == ST_WAITING) thr_state[w[2:0]] = ST_READY;
          elect_next();
        end else if (func == FN_JOIN) begin
          if (tgt == cur || thr_state[tgt] == ST_EMPTY || thr_state[tgt] == ST_DEAD) begin
            st = STAT_NOTHR;
          end else begin
            thr_waiter[tgt] = {1'b0, cur};
            if (thr_state[tgt] == ST_ZOMBIE) begin
              join_hit = 1'b1;
              join_val = thr_exit_val[tgt];
              thr_state[tgt] = ST_DEAD;
            end else begin
              thr_state[cur] = ST_WAITING;
              thr_joining[cur] = {1'b0, tgt};
              elect_next();
            end
          end
        end else begin
          if (thr_state[cur] == ST_RUNNING) thr_state[cur] = ST_WAITING;
          elect_next();
        end
      end
      default: ;
    endcase
    if (sched_idle) st = STAT_IDLE;
    r.status = st;
    r.new_slot = nslot;
    r.running_slot = sched_idle ? 3'd0 : cur_slot;
    r.running_valid = ~sched_idle;
    r.switched = (was_idle != sched_idle) || (!sched_idle && was_slot != cur_slot);
    r.join_done = join_hit;
    r.join_value = join_hit ? join_val : 32'd0;
    if (join_hit) n_joins++;
  endtask

  // Hold the request until it is taken; idle in bursts unless told to stay quiet.
  // Valid stays high into the next request when there is no gap.
  task automatic send_op(input logic [2:0] func, input logic [2:0] tgt, input logic [31:0] rv);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= func;
    req.target_slot <= tgt;
    req.ret_value <= rv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    n_sent++;
  endtask

  // Predict at the accepting edge, in the same order the block sees requests.
  always @(posedge clk) begin
    sched_result_t r;
    if (!rst && req.valid && req.ready) begin
      schedule_op(req.func, req.target_slot, req.ret_value, r);
      // hold a typed directed result against the prediction
      if (typed_exp.exists(n_pred) && typed_exp[n_pred] !== r) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("directed transaction %0d: expected %p, predicted %p",
                   n_pred, typed_exp[n_pred], r);
      end
      pending_results.push_back(r);
      n_pred++;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    sched_result_t want;
    sched_result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.new_slot, rsp.running_slot, rsp.running_valid,
              rsp.switched, rsp.join_done, rsp.join_value};
      n_checked++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Stall the result side in random bursts; none in the quiet tail.
  initial begin
    int len;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 2) != 0) begin
        len = $urandom_range(1, 30);
        rsp.ready <= 1'b1;
        repeat (len) @(posedge clk);
      end else begin
        len = $urandom_range(1, 19);
        rsp.ready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  // Weighted random operations with uniformly random targets and random exit values;
  // a small share uses the unused codes 6 and 7.
  function automatic logic [2:0] pick_func();
    int p;
    p = $urandom_range(0, 99);
    if (p < 22) return FN_CREATE;
    if (p < 40) return FN_YIELD;
    if (p < 55) return FN_EXIT;
    if (p < 72) return FN_JOIN;
    if (p < 82) return FN_WAIT;
    if (p < 96) return FN_NOTIFY;
    return 3'($urandom_range(6, 7));
  endfunction

  initial begin
    op_row_t rows[$];
    op_row_t row;
    logic [31:0] rv;
    req.valid <= 1'b0;
    req.func <= FN_CREATE;
    req.target_slot <= '0;
    req.ret_value <= '0;
    clear_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Typed rows: results readable straight from reset.
    rows.push_back('{FN_YIELD, 3'd0, 32'd0, 1'b1, '{STAT_IDLE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0}});
    rows.push_back('{FN_NOTIFY, 3'd7, 32'd0, 1'b1, '{STAT_IDLE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0}});
    rows.push_back('{FN_CREATE, 3'd0, 32'd0, 1'b1, '{STAT_OK, 3'd0, 3'd0, 1'b1, 1'b1, 1'b0, 32'd0}});
    rows.push_back('{FN_JOIN, 3'd0, 32'd0, 1'b1, '{STAT_NOTHR, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 32'd0}});
    for (int i = 1; i < 8; i++) rows.push_back('{FN_CREATE, 3'd0, 32'd0, 1'b0, '0});
    rows.push_back('{FN_CREATE, 3'd0, 32'd0, 1'b1, '{STAT_FULL, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, 32'd0}});
    rows.push_back('{FN_JOIN, 3'd7, 32'd0, 1'b0, '0});
    rows.push_back('{FN_EXIT, 3'd0, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{FN_EXIT, 3'd0, 32'h0000_0000, 1'b0, '0});
    rows.push_back('{FN_JOIN, 3'd1, 32'd0, 1'b0, '0});
    rows.push_back('{FN_WAIT, 3'd0, 32'd0, 1'b0, '0});
    rows.push_back('{FN_NOTIFY, 3'd0, 32'd0, 1'b0, '0});
    rows.push_back('{3'd6, 3'd5, 32'hA5A5_5A5A, 1'b0, '0});
    rows.push_back('{3'd7, 3'd2, 32'h5A5A_A5A5, 1'b0, '0});
    rows.push_back('{FN_YIELD, 3'd0, 32'd0, 1'b0, '0});
    rows.push_back('{FN_EXIT, 3'd0, 32'h1234_5678, 1'b0, '0});
    rows.push_back('{FN_JOIN, 3'd3, 32'd0, 1'b0, '0});

    foreach (rows[i]) begin
      row = rows[i];
      if (row.typed) typed_exp[n_sent] = row.res;
      send_op(row.func, row.tgt, row.rv);
    end

    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k > RANDOM_OPS - 80) quiet = 1'b1;
      rv = $urandom();
      send_op(pick_func(), 3'($urandom_range(0, 7)), rv);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Drain the pending predictions, let the last results settle, then report.
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("sent %0d operations, checked %0d results, %0d joins completed",
             n_sent, n_checked, n_joins);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: worst case is far below this.
  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
